@@ hw/rtl/lfu_cache_table_top_assert.svh @@
// ---------------------------------------------------------------------------
// lfu_cache_table_top_assert.svh
// Assertion macros for the LFU cache table.
// ---------------------------------------------------------------------------
`ifndef LFU_CACHE_TABLE_TOP_ASSERT_SVH
`define LFU_CACHE_TABLE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define LFU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfu assertion failed");
// next-cycle implication
`define LFU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfu assertion failed");
`else
`define LFU_ASSERT_NOW(lbl, ante, cons)
`define LFU_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ hw/rtl/lfu_pkg.sv @@
// ---------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants of the LFU cache table.
// ---------------------------------------------------------------------------
package lfu_pkg;

    localparam int IDX_W  = 10;   // slot index, covers up to 1024 slots
    localparam int RANK_W = 10;   // age rank carried on the chain
    localparam int KEY_W  = 32;
    localparam int DAT_W  = 32;
    localparam int CNT_W  = 32;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } state_t;

    // search token walking the cell chain
    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic              hit;
        logic [IDX_W-1:0]  hit_idx;
        logic [RANK_W-1:0] hit_rank;
        logic [DAT_W-1:0]  hit_data;
        logic              free;
        logic [IDX_W-1:0]  free_idx;
        logic              vic;
        logic [IDX_W-1:0]  vic_idx;
        logic [CNT_W-1:0]  vic_cnt;
        logic [RANK_W-1:0] vic_rank;
        logic [KEY_W-1:0]  vic_key;
    } tok_t;

    // update broadcast to all cells
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  sel_idx;
        logic              inc_all;
        logic [RANK_W-1:0] rank;
        logic              insert;
        logic              wr_data;
        logic [KEY_W-1:0]  key;
        logic [DAT_W-1:0]  data;
    } cmd_t;

endpackage

@@ hw/rtl/lfu_cache_table_top.sv @@
// ---------------------------------------------------------------------------
// lfu_cache_table_top
// LFU key-value table with LRU tiebreak, built as a chain of slot cells.
// ---------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  cmd      in         start & !busy          func, key, value
//  result   out        done (one cycle)       hit, read_value, evicted, evicted_key
//  cfg      in         cfg_valid & cfg_ready  cfg_data (capacity)
//
// From accept to done, the search token walks the cell chain one slot per
// cycle, then the update is applied and the result is registered.
// Reset clears all valid marks at once; no clearing pass.
// busy is high from accept until done; the result receiver cannot stall.
// ---------------------------------------------------------------------------
module lfu_cache_table_top #(
    parameter int CAPACITY = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               func,
    input  logic signed [31:0] key,
    input  logic signed [31:0] value,
    output logic               done,
    output logic               hit,
    output logic signed [31:0] read_value,
    output logic               evicted,
    output logic signed [31:0] evicted_key,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [4:0]         cfg_data
);

`include "lfu_cache_table_top_assert.svh"

    localparam int RW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int FW = $clog2(CAPACITY + 1);
    localparam int CW = 11;

    lfu_pkg::state_t state_reg, state_next;
    logic [4:0]      cap_reg;
    logic [FW-1:0]   fill_reg, fill_next;
    logic            func_reg;
    logic [31:0]     value_reg;
    logic            done_reg, hit_reg, evicted_reg;
    logic [31:0]     rv_reg, ek_reg;
    logic            r_hit, r_ev;
    logic [31:0]     r_rv, r_ek;
    logic [CW-1:0]   cap_x, cap_eff;
    logic            apply;
    lfu_pkg::tok_t   tok [CAPACITY+1];
    lfu_pkg::tok_t   last;
    lfu_pkg::cmd_t   cmd;

    assign cfg_ready = 1'b1;
    assign busy      = (state_reg != lfu_pkg::ST_IDLE);

    // token entering the first cell at the accept edge
    always_comb
    begin
        tok[0]       = '0;
        tok[0].valid = start && !busy;
        tok[0].key   = key;
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        lfu_cell #(
            .IDX (i),
            .RW  (RW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1]),
            .cmd     (cmd)
        );
    end

    assign last    = tok[CAPACITY];
    assign apply   = (state_reg == lfu_pkg::ST_SCAN) && last.valid;
    assign cap_x   = CW'(cap_reg);
    assign cap_eff = (cap_x > CW'(CAPACITY)) ? CW'(CAPACITY) : cap_x;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lfu_pkg::ST_IDLE: if (start) state_next = lfu_pkg::ST_SCAN;
            lfu_pkg::ST_SCAN: if (last.valid) state_next = lfu_pkg::ST_IDLE;
            default:          state_next = lfu_pkg::ST_IDLE;
        endcase
    end

    // update command and result
    always_comb
    begin
        cmd       = '0;
        cmd.key   = last.key;
        cmd.data  = value_reg;
        r_hit     = 1'b0;
        r_rv      = '0;
        r_ev      = 1'b0;
        r_ek      = '0;
        fill_next = fill_reg;
        if (apply)
        begin
            if (!func_reg)
            begin
                if (last.hit)
                begin
                    r_hit       = 1'b1;
                    r_rv        = last.hit_data;
                    cmd.en      = 1'b1;
                    cmd.sel_idx = last.hit_idx;
                    cmd.rank    = last.hit_rank;
                end
            end
            else if (cap_eff != '0)
            begin
                cmd.en = 1'b1;
                if (last.hit)
                begin
                    r_hit       = 1'b1;
                    cmd.sel_idx = last.hit_idx;
                    cmd.rank    = last.hit_rank;
                    cmd.wr_data = 1'b1;
                end
                else if (CW'(fill_reg) < cap_eff)
                begin
                    cmd.insert  = 1'b1;
                    cmd.inc_all = 1'b1;
                    cmd.sel_idx = last.free_idx;
                    fill_next   = fill_reg + FW'(1);
                end
                else
                begin
                    // evict and reuse the slot: fill stays the same
                    cmd.insert  = 1'b1;
                    cmd.sel_idx = last.vic_idx;
                    cmd.rank    = last.vic_rank;
                    r_ev        = 1'b1;
                    r_ek        = last.vic_key;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lfu_pkg::ST_IDLE;
            cap_reg   <= 5'd16;
            fill_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            done_reg  <= apply;
            if (cfg_valid && cfg_ready)
                cap_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            func_reg  <= func;
            value_reg <= value;
        end
        if (apply)
        begin
            hit_reg     <= r_hit;
            rv_reg      <= r_rv;
            evicted_reg <= r_ev;
            ek_reg      <= r_ek;
        end
    end

    assign done        = done_reg;
    assign hit         = hit_reg;
    assign read_value  = rv_reg;
    assign evicted     = evicted_reg;
    assign evicted_key = ek_reg;

    `LFU_ASSERT_NEXT(a_done_after_scan, apply, done)
    `LFU_ASSERT_NOW(a_idle_at_done, done, !busy)
    `LFU_ASSERT_NOW(a_evict_not_hit, done && evicted, !hit)
    `LFU_ASSERT_NOW(a_fill_bound, 1'b1, CW'(fill_reg) <= CW'(CAPACITY))

endmodule

@@ hw/rtl/lfu_cell.sv @@
// ---------------------------------------------------------------------------
// lfu_cell
// One table slot: holds an entry and folds it into the passing search token.
// ---------------------------------------------------------------------------
module lfu_cell #(
    parameter int IDX = 0,
    parameter int RW  = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  lfu_pkg::tok_t tok_in,
    output lfu_pkg::tok_t tok_out,
    input  lfu_pkg::cmd_t cmd
);

    localparam logic [lfu_pkg::IDX_W-1:0] MY_IDX = lfu_pkg::IDX_W'(IDX);

    logic                      valid_reg, valid_next;
    logic [lfu_pkg::KEY_W-1:0] key_reg, key_next;
    logic [lfu_pkg::DAT_W-1:0] data_reg, data_next;
    logic [lfu_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [RW-1:0]             rank_reg, rank_next;
    logic                      tval_reg;
    lfu_pkg::tok_t             tok_reg, tok_next;
    logic [lfu_pkg::RANK_W-1:0] rank_x;

    assign rank_x = lfu_pkg::RANK_W'(rank_reg);

    // token update
    always_comb
    begin
        tok_next = tok_in;
        if (valid_reg && key_reg == tok_in.key)
        begin
            tok_next.hit      = 1'b1;
            tok_next.hit_idx  = MY_IDX;
            tok_next.hit_rank = rank_x;
            tok_next.hit_data = data_reg;
        end
        if (!valid_reg && !tok_in.free)
        begin
            tok_next.free     = 1'b1;
            tok_next.free_idx = MY_IDX;
        end
        // smallest count, oldest among ties
        if (valid_reg && (!tok_in.vic || cnt_reg < tok_in.vic_cnt ||
            (cnt_reg == tok_in.vic_cnt && rank_x > tok_in.vic_rank)))
        begin
            tok_next.vic      = 1'b1;
            tok_next.vic_idx  = MY_IDX;
            tok_next.vic_cnt  = cnt_reg;
            tok_next.vic_rank = rank_x;
            tok_next.vic_key  = key_reg;
        end
    end

    // entry update
    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        data_next  = data_reg;
        cnt_next   = cnt_reg;
        rank_next  = rank_reg;
        if (cmd.en)
        begin
            if (cmd.sel_idx == MY_IDX)
            begin
                rank_next = '0;
                if (cmd.insert)
                begin
                    valid_next = 1'b1;
                    key_next   = cmd.key;
                    data_next  = cmd.data;
                    cnt_next   = lfu_pkg::CNT_W'(1);
                end
                else
                begin
                    if (cnt_reg != '1)
                        cnt_next = cnt_reg + lfu_pkg::CNT_W'(1);
                    if (cmd.wr_data)
                        data_next = cmd.data;
                end
            end
            else if (valid_reg && (cmd.inc_all || rank_x < cmd.rank))
            begin
                rank_next = rank_reg + RW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tval_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            tval_reg  <= tok_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        data_reg <= data_next;
        cnt_reg  <= cnt_next;
        rank_reg <= rank_next;
        tok_reg  <= tok_next;
    end

    always_comb
    begin
        tok_out       = tok_reg;
        tok_out.valid = tval_reg;
    end

endmodule
